// ----- rtl/core/rpsu_pkg.sv -----
// ----------------------------------------------------------------------------
// rpsu_pkg
// Shared types and codes for the raster pixel stream unpacker.
// ----------------------------------------------------------------------------
package rpsu_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_BPP   = 2'd2;

  localparam logic [2:0] BPP_NONE = 3'd0;
  localparam logic [2:0] BPP_2    = 3'd2;
  localparam logic [2:0] BPP_3    = 3'd3;
  localparam logic [2:0] BPP_4    = 3'd4;

  localparam logic [2:0] HDR_BYTES = 3'd6;
  localparam logic [2:0] HDR_SAT   = 3'd7;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       chunk_end;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] argb;
    logic        row_done;
  } res_t;

  typedef struct packed {
    logic [23:0] px;
    logic        hi_color;
  } fmt_req_t;

endpackage

// ----- rtl/core/rpsu_stream_if.sv -----
// ----------------------------------------------------------------------------
// rpsu_stream_if
// Valid/ready channels for stream input requests and result requests.
// ----------------------------------------------------------------------------
interface rpsu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, output op, output data_byte, output chunk_end,
                  input ready);
  modport sink   (input valid, input op, input data_byte, input chunk_end,
                  output ready);
endinterface

interface rpsu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [31:0] argb;
  logic        row_done;

  modport source (output valid, output kind, output pos_x, output pos_y,
                  output argb, output row_done, input ready);
  modport sink   (input valid, input kind, input pos_x, input pos_y,
                  input argb, input row_done, output ready);
endinterface

// ----- rtl/core/rpsu_fmt.sv -----
// ----------------------------------------------------------------------------
// rpsu_fmt
// Converts an assembled pixel word into opaque ARGB.
// ----------------------------------------------------------------------------
module rpsu_fmt (
  input  rpsu_pkg::fmt_req_t req_i,
  output logic [31:0]        argb_o
);
  import rpsu_pkg::*;

  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  always_comb begin
    if (req_i.hi_color) begin
      // 5-5-5 word, each channel widened by a left shift
      red   = {req_i.px[4:0], 3'b000};
      green = {req_i.px[9:5], 3'b000};
      blue  = {req_i.px[14:10], 3'b000};
    end else begin
      red   = req_i.px[7:0];
      green = req_i.px[15:8];
      blue  = req_i.px[23:16];
    end
    argb_o = {ALPHA_OPAQUE, red, green, blue};
  end

endmodule

// ----- rtl/core/rpsu_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpsu_ctrl
// Frame state: header capture, pixel byte assembly and x/y position.
// ----------------------------------------------------------------------------
module rpsu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rpsu_pkg::item_t item_i,
  output logic            res_vld_o,
  output rpsu_pkg::res_t  res_o
);
  import rpsu_pkg::*;

  logic        active_q, active_d;
  logic        hdr_vld_q, hdr_vld_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [47:0] hdr_sh_q, hdr_sh_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [2:0]  bpp_q, bpp_d;
  logic [1:0]  phase_q, phase_d;
  logic [23:0] acc_q, acc_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;

  logic [47:0] hdr_new;
  logic [2:0]  cnt_inc;
  logic [12:0] bpp_raw;
  logic [23:0] acc_new;
  logic [16:0] col_inc;
  logic [16:0] row_inc;
  logic        bpp_ok;
  logic        more_bytes;
  fmt_req_t    fmt_req;
  logic [31:0] argb;

  assign hdr_new    = {hdr_sh_q[39:0], item_i.data_byte};
  assign cnt_inc    = (hdr_cnt_q == HDR_SAT) ? HDR_SAT : hdr_cnt_q + 3'd1;
  assign bpp_raw    = hdr_new[47:35];
  assign acc_new    = acc_q | ({16'd0, item_i.data_byte} << {phase_q, 3'b000});
  assign col_inc    = {1'b0, col_q} + 17'd1;
  assign row_inc    = {1'b0, row_q} + 17'd1;
  assign bpp_ok     = (bpp_q == BPP_2) || (bpp_q == BPP_3) || (bpp_q == BPP_4);
  assign more_bytes = ({1'b0, phase_q} + 3'd1) < bpp_q;

  assign fmt_req.px       = acc_new;
  assign fmt_req.hi_color = (bpp_q == BPP_2);

  rpsu_fmt u_fmt (
    .req_i  (fmt_req),
    .argb_o (argb)
  );

  always_comb begin
    active_d  = active_q;
    hdr_vld_d = hdr_vld_q;
    hdr_cnt_d = hdr_cnt_q;
    hdr_sh_d  = hdr_sh_q;
    width_d   = width_q;
    height_d  = height_q;
    bpp_d     = bpp_q;
    phase_d   = phase_q;
    acc_d     = acc_q;
    col_d     = col_q;
    row_d     = row_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (en_i) begin
      case (item_i.op)
        OP_START: begin
          active_d  = 1'b1;
          hdr_vld_d = 1'b0;
          hdr_cnt_d = '0;
          hdr_sh_d  = '0;
          phase_d   = '0;
          acc_d     = '0;
          col_d     = '0;
          row_d     = '0;
        end
        OP_END: begin
          active_d   = 1'b0;
          res_vld_o  = 1'b1;
          res_o.kind = KIND_DONE;
        end
        OP_DATA: begin
          if (active_q && !hdr_vld_q) begin
            hdr_sh_d  = hdr_new;
            hdr_cnt_d = cnt_inc;
            if (item_i.chunk_end) begin
              hdr_cnt_d = '0;
              if (cnt_inc == HDR_BYTES) begin
                width_d   = hdr_new[31:16];
                height_d  = hdr_new[15:0];
                hdr_vld_d = 1'b1;
                phase_d   = '0;
                acc_d     = '0;
                if (bpp_raw == 13'd2 || bpp_raw == 13'd3 || bpp_raw == 13'd4) begin
                  bpp_d = bpp_raw[2:0];
                end else begin
                  bpp_d      = BPP_NONE;
                  res_vld_o  = 1'b1;
                  res_o.kind = KIND_BPP;
                end
              end
            end
          end else if (active_q && bpp_ok) begin
            if (more_bytes) begin
              acc_d   = acc_new;
              phase_d = phase_q + 2'd1;
            end else begin
              phase_d        = '0;
              acc_d          = '0;
              res_vld_o      = 1'b1;
              res_o.kind     = KIND_PIXEL;
              res_o.pos_x    = col_q;
              res_o.pos_y    = row_q;
              res_o.argb     = argb;
              col_d          = col_inc[15:0];
              if (col_inc >= {1'b0, width_q}) begin
                col_d          = '0;
                res_o.row_done = 1'b1;
                row_d          = (row_inc >= {1'b0, height_q}) ? 16'd0 : row_inc[15:0];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      hdr_vld_q <= 1'b0;
      hdr_cnt_q <= '0;
      hdr_sh_q  <= '0;
      width_q   <= '0;
      height_q  <= '0;
      bpp_q     <= BPP_NONE;
      phase_q   <= '0;
      acc_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      active_q  <= active_d;
      hdr_vld_q <= hdr_vld_d;
      hdr_cnt_q <= hdr_cnt_d;
      hdr_sh_q  <= hdr_sh_d;
      width_q   <= width_d;
      height_q  <= height_d;
      bpp_q     <= bpp_d;
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

`ifndef ASSERT_OFF
  a_bpp_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bpp_q == BPP_NONE || bpp_q == BPP_2 || bpp_q == BPP_3 || bpp_q == BPP_4)
    else $error("bytes per pixel holds an illegal value");
  a_phase_below_bpp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_vld_q && bpp_ok) |-> ({1'b0, phase_q} < bpp_q))
    else $error("byte phase ran past pixel size");
`endif

endmodule

// ----- rtl/core/raster_pixel_stream_unpacker_unit.sv -----
// An accepted request is held in the input register; its result, if any, is written
// into the result register when that register is empty or being taken.
// One request per cycle unless the result side stalls; input and result registers
// decouple the two sides. A request with no result still passes the input register.
// Reset (rst_ni low, asynchronous) clears all frame state and empties both registers.
// ----------------------------------------------------------------------------
// raster_pixel_stream_unpacker_unit
// Byte stream to ARGB pixel unpacker with frame header capture.
// ----------------------------------------------------------------------------
module raster_pixel_stream_unpacker_unit (
  input  logic clk_i,
  input  logic rst_ni,
  rpsu_in_if.sink    in_i,
  rpsu_out_if.source out_o
);
  import rpsu_pkg::*;

  item_t in_q;
  logic  in_vld_q, in_vld_d;
  res_t  out_q;
  logic  out_vld_q, out_vld_d;
  logic  adv;
  logic  res_vld;
  res_t  res;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || adv;

  rpsu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (in_vld_q && adv),
    .item_i    (in_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_comb begin
    in_vld_d  = in_vld_q;
    out_vld_d = out_vld_q;
    if (in_i.ready) begin
      in_vld_d = in_i.valid;
    end
    if (adv) begin
      out_vld_d = in_vld_q && res_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.op        <= in_i.op;
      in_q.data_byte <= in_i.data_byte;
      in_q.chunk_end <= in_i.chunk_end;
    end
    if (adv && in_vld_q && res_vld) begin
      out_q <= res;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.kind     = out_q.kind;
  assign out_o.pos_x    = out_q.pos_x;
  assign out_o.pos_y    = out_q.pos_y;
  assign out_o.argb     = out_q.argb;
  assign out_o.row_done = out_q.row_done;

`ifndef ASSERT_OFF
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while pending request is stalled");
  a_end_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && adv && in_q.op == OP_END) |=> (out_vld_q && out_q.kind == KIND_DONE))
    else $error("end request produced no frame done");
  a_pixel_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.kind == KIND_PIXEL) |-> (out_q.argb[31:24] == ALPHA_OPAQUE))
    else $error("pixel result is not opaque");
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.kind != KIND_PIXEL) |->
      (out_q.argb == 32'd0 && out_q.pos_x == 16'd0 && out_q.pos_y == 16'd0 &&
       !out_q.row_done))
    else $error("status result carries pixel fields");
`endif

endmodule

// ----- verif/tb_raster_pixel_stream_unpacker_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_raster_pixel_stream_unpacker_unit
// Drives start, data and end requests into the unpacker and scoreboards every
// result request against an in-bench pixel unpacker model. A short directed
// table comes first, then random frames with headers, pixel data and noise,
// with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_raster_pixel_stream_unpacker_unit;
  import rpsu_pkg::*;

  typedef struct {
    item_t it;
    bit    typed;
    bit    has;
    res_t  res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  rpsu_in_if  in_if ();
  rpsu_out_if out_if ();

  raster_pixel_stream_unpacker_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // unpacker model state
  bit          frm_active;
  bit          hdr_taken;
  logic [2:0]  hdr_cnt;
  logic [47:0] hdr_sr;
  logic [15:0] frm_w;
  logic [15:0] frm_h;
  logic [2:0]  px_bytes;
  logic [1:0]  px_phase;
  logic [23:0] px_acc;
  logic [15:0] cur_col;
  logic [15:0] cur_row;

  res_t     pending_res[$];
  dir_row_t plan[$];

  int  mismatches;
  int  n_req;
  int  n_pixels;
  int  n_done;
  int  n_depth;
  bit  calm;
  int  stall_left;

  always #2 clk_i = ~clk_i;

  task automatic unpack_byte(input item_t it, output bit has, output res_t r);
    logic [15:0] depth;
    logic [31:0] px;
    logic [16:0] nx;
    logic [16:0] ny;
    has = 1'b0;
    r   = '0;
    if (it.op == OP_START) begin
      frm_active = 1'b1;
      hdr_taken  = 1'b0;
      hdr_cnt    = '0;
      hdr_sr     = '0;
      px_phase   = '0;
      px_acc     = '0;
      cur_col    = '0;
      cur_row    = '0;
    end else if (it.op == OP_END) begin
      frm_active = 1'b0;
      has        = 1'b1;
      r.kind     = KIND_DONE;
    end else if (it.op == OP_DATA && frm_active) begin
      if (!hdr_taken) begin
        hdr_sr = {hdr_sr[39:0], it.data_byte};
        if (hdr_cnt != HDR_SAT) hdr_cnt = hdr_cnt + 3'd1;
        if (it.chunk_end) begin
          if (hdr_cnt == HDR_BYTES) begin
            depth     = hdr_sr[47:32] >> 3;
            frm_w     = hdr_sr[31:16];
            frm_h     = hdr_sr[15:0];
            hdr_taken = 1'b1;
            px_phase  = '0;
            px_acc    = '0;
            if (depth >= 16'd2 && depth <= 16'd4) begin
              px_bytes = depth[2:0];
            end else begin
              px_bytes = BPP_NONE;
              has      = 1'b1;
              r.kind   = KIND_BPP;
            end
          end
          hdr_cnt = '0;
        end
      end else if (px_bytes != BPP_NONE) begin
        if ({1'b0, px_phase} + 3'd1 < px_bytes) begin
          px_acc   = px_acc | (24'(it.data_byte) << (8 * px_phase));
          px_phase = px_phase + 2'd1;
        end else begin
          px = {8'h00, px_acc} | (32'(it.data_byte) << (8 * px_phase));
          has     = 1'b1;
          r.kind  = KIND_PIXEL;
          r.pos_x = cur_col;
          r.pos_y = cur_row;
          if (px_bytes == BPP_2) begin
            r.argb = {ALPHA_OPAQUE, px[4:0], 3'b000, px[9:5], 3'b000, px[14:10], 3'b000};
          end else begin
            r.argb = {ALPHA_OPAQUE, px[7:0], px[15:8], px[23:16]};
          end
          px_phase = '0;
          px_acc   = '0;
          nx = {1'b0, cur_col} + 17'd1;
          if (nx >= {1'b0, frm_w}) begin
            cur_col    = '0;
            r.row_done = 1'b1;
            ny = {1'b0, cur_row} + 17'd1;
            cur_row = (ny >= {1'b0, frm_h}) ? 16'd0 : ny[15:0];
          end else begin
            cur_col = nx[15:0];
          end
        end
      end
    end
  endtask

  task automatic push_req(input item_t it, input bit typed, input bit t_has,
                          input res_t t_res);
    bit   has;
    res_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_if.op        <= it.op;
    in_if.data_byte <= it.data_byte;
    in_if.chunk_end <= it.chunk_end;
    in_if.valid     <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    unpack_byte(it, has, r);
    if (typed) begin
      has = t_has;
      r   = t_res;
    end
    if (has) pending_res.push_back(r);
    if (it.op != OP_RSVD) n_req++;
    @(negedge clk_i);
  endtask

  task automatic send(input logic [1:0] op, input logic [7:0] b, input logic last);
    push_req(item_t'{op: op, data_byte: b, chunk_end: last}, 1'b0, 1'b0, '0);
  endtask

  function automatic void add_row(logic [1:0] op, logic [7:0] b, logic last, bit typed,
                                  bit has, res_t res);
    dir_row_t row;
    row.it    = item_t'{op: op, data_byte: b, chunk_end: last};
    row.typed = typed;
    row.has   = has;
    row.res   = res;
    plan.push_back(row);
  endfunction

  task automatic send_chunk(input int len);
    for (int i = 0; i < len; i++) send(OP_DATA, 8'($urandom), i == len - 1);
  endtask

  task automatic send_frame();
    logic [15:0] bpp;
    logic [15:0] w;
    logic [15:0] h;
    int          sel;
    int          len;
    send(OP_START, 8'($urandom), 1'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, 10);
      if (len == 6) len = 7 + $urandom_range(0, 3);
      send_chunk(len);
    end
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: bpp = 16'(16 + $urandom_range(0, 7));
      3, 4, 5: bpp = 16'(24 + $urandom_range(0, 7));
      6, 7:    bpp = 16'(32 + $urandom_range(0, 7));
      8:       bpp = 16'($urandom);
      default: bpp = 16'($urandom_range(0, 15));
    endcase
    w = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    h = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    send(OP_DATA, bpp[15:8], 1'b0);
    send(OP_DATA, bpp[7:0], 1'b0);
    send(OP_DATA, w[15:8], 1'b0);
    send(OP_DATA, w[7:0], 1'b0);
    send(OP_DATA, h[15:8], 1'b0);
    send(OP_DATA, h[7:0], 1'b1);
    len = $urandom_range(0, 40);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        send(2'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        send(OP_DATA, 8'($urandom), $urandom_range(0, 7) == 0);
      end
    end
    if ($urandom_range(0, 3) != 0) send(OP_END, 8'($urandom), 1'($urandom));
    if ($urandom_range(0, 5) == 0) send(2'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic check_field(input string name, input logic [31:0] e,
                             input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0d x %0d y %0d argb %h",
                 $time, out_if.kind, out_if.pos_x, out_if.pos_y, out_if.argb);
        mismatches++;
      end else begin
        e = pending_res.pop_front();
        check_field("kind", 32'(e.kind), 32'(out_if.kind));
        check_field("pos_x", 32'(e.pos_x), 32'(out_if.pos_x));
        check_field("pos_y", 32'(e.pos_y), 32'(out_if.pos_y));
        check_field("argb", e.argb, out_if.argb);
        check_field("row_done", 32'(e.row_done), 32'(out_if.row_done));
        case (e.kind)
          KIND_PIXEL: n_pixels++;
          KIND_DONE:  n_done++;
          default:    n_depth++;
        endcase
      end
    end
  end

  // result side backpressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 17);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    res_t none;
    none = '0;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    calm             = 1'b0;
    stall_left       = 0;
    in_if.valid      = 1'b0;
    in_if.op         = OP_START;
    in_if.data_byte  = '0;
    in_if.chunk_end  = 1'b0;
    out_if.ready     = 1'b0;
    frm_active = 1'b0;
    hdr_taken  = 1'b0;
    hdr_cnt    = '0;
    hdr_sr     = '0;
    frm_w      = '0;
    frm_h      = '0;
    px_bytes   = BPP_NONE;
    px_phase   = '0;
    px_acc     = '0;
    cur_col    = '0;
    cur_row    = '0;

    // end with no frame open, ignored requests, dropped short header
    add_row(OP_END, 8'h00, 1'b0, 1, 1, res_t'{KIND_DONE, 16'h0, 16'h0, 32'h0, 1'b0});
    add_row(OP_DATA, 8'hff, 1'b1, 1, 0, none);
    add_row(OP_RSVD, 8'hff, 1'b1, 1, 0, none);
    add_row(OP_START, 8'h00, 1'b0, 1, 0, none);
    add_row(OP_DATA, 8'h00, 1'b1, 1, 0, none);
    // 16 bpp, width 2, height 0
    add_row(OP_DATA, 8'h00, 1'b0, 1, 0, none);
    add_row(OP_DATA, 8'h10, 1'b0, 1, 0, none);
    add_row(OP_DATA, 8'h00, 1'b0, 1, 0, none);
    add_row(OP_DATA, 8'h02, 1'b0, 1, 0, none);
    add_row(OP_DATA, 8'h00, 1'b0, 1, 0, none);
    add_row(OP_DATA, 8'h00, 1'b1, 1, 0, none);
    add_row(OP_DATA, 8'hff, 1'b0, 1, 0, none);
    add_row(OP_DATA, 8'h7f, 1'b0, 1, 1,
            res_t'{KIND_PIXEL, 16'h0, 16'h0, 32'hfff8f8f8, 1'b0});
    // pixel split across chunks
    add_row(OP_DATA, 8'h00, 1'b1, 0, 0, none);
    add_row(OP_DATA, 8'h00, 1'b0, 0, 0, none);
    add_row(OP_END, 8'hff, 1'b1, 1, 1, res_t'{KIND_DONE, 16'h0, 16'h0, 32'h0, 1'b0});
    // unsupported depth, all-ones header
    add_row(OP_START, 8'hff, 1'b1, 1, 0, none);
    for (int i = 0; i < 5; i++) add_row(OP_DATA, 8'hff, 1'b0, 1, 0, none);
    add_row(OP_DATA, 8'hff, 1'b1, 1, 1, res_t'{KIND_BPP, 16'h0, 16'h0, 32'h0, 1'b0});
    add_row(OP_DATA, 8'h55, 1'b0, 1, 0, none);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) push_req(plan[i].it, plan[i].typed, plan[i].has, plan[i].res);
    while (n_req < 1150 + plan.size()) begin
      if (n_req > 1000) calm = 1'b1;
      send_frame();
    end
    in_if.valid <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_res.size() != 0) mismatches++;

    $display("Sent %0d requests; checked %0d pixels, %0d frame ends, %0d depth errors.",
             n_req, n_pixels, n_done, n_depth);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rpsu_pkg.sv
rtl/core/rpsu_stream_if.sv
rtl/core/rpsu_fmt.sv
rtl/core/rpsu_ctrl.sv
rtl/core/raster_pixel_stream_unpacker_unit.sv
verif/tb_raster_pixel_stream_unpacker_unit.sv
